### design/dsw_pkg.sv
// Shared types and constants for the debounced stopwatch digit display.
// Used by dsw_div_stage, dsw_breath, the top level, the checker and the testbench.
package dsw_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned DEBOUNCE_SAMPLES_DEF = 16;
    localparam logic [PERIOD_W-1:0] BREATH_PERIOD_RESET = 16'd1249;

    // Constant-divisor chain, LSD first: ms units, ms tens, ms hundreds,
    // sec units, sec tens, min units, min tens, hour units.
    localparam int unsigned NUM_STAGES = 8;
    localparam int unsigned DIGIT_DIV [NUM_STAGES] = '{10, 10, 10, 10, 6, 10, 6, 10};

    localparam int unsigned DIG_MS_UNITS = 0;
    localparam int unsigned DIG_MS_TENS = 1;
    localparam int unsigned DIG_MS_HUNDREDS = 2;
    localparam int unsigned DIG_SEC_UNITS = 3;
    localparam int unsigned DIG_SEC_TENS = 4;
    localparam int unsigned DIG_MIN_UNITS = 5;
    localparam int unsigned DIG_MIN_TENS = 6;
    localparam int unsigned DIG_HOUR_UNITS = 7;

    localparam int unsigned CNT_W = $clog2(TIME_W + NUM_STAGES + 2);

    // One bit of a serial stream, MSB first
    typedef struct packed {
        logic en;
        logic dat;
    } serial_bit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

### design/dsw_div_stage.sv
// Bit-serial divider by a small constant: quotient bits stream out MSB first,
// remainder is left in the stage as the digit. Depends on dsw_pkg.
module dsw_div_stage #(
    parameter int unsigned DIVISOR = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  dsw_pkg::serial_bit_t        link_in,
    output dsw_pkg::serial_bit_t        link_out,
    output logic [$clog2(DIVISOR)-1:0]  digit
);

    localparam int unsigned RW = $clog2(DIVISOR);
    localparam logic [RW:0] DIV_V = (RW+1)'(DIVISOR);

    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic [RW:0]   trial;
    logic          q_bit;
    dsw_pkg::serial_bit_t link_reg;
    dsw_pkg::serial_bit_t link_next;

    always_comb
    begin
        trial = {rem_reg, link_in.dat};
        q_bit = (trial >= DIV_V);
        if (q_bit)
        begin
            rem_next = RW'(trial - DIV_V);
        end
        else
        begin
            rem_next = trial[RW-1:0];
        end
        link_next.en = link_in.en;
        link_next.dat = q_bit;
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            rem_reg <= '0;
        end
        else if (link_in.en)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else if (clear)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign digit = rem_reg;

endmodule

### design/dsw_breath.sv
// Bit-serial remainder of the elapsed time by twice the breath period,
// folded into a triangle compare value. Depends on dsw_pkg.
module dsw_breath (
    input  logic                           clk,
    input  logic                           clear,
    input  dsw_pkg::serial_bit_t           bit_in,
    input  logic [dsw_pkg::PERIOD_W-1:0]   period,
    output logic [dsw_pkg::PERIOD_W-1:0]   compare
);

    localparam int unsigned PW = dsw_pkg::PERIOD_W;
    localparam int unsigned RW = PW + 1;

    logic [RW-1:0] r_reg;
    logic [RW-1:0] r_next;
    logic [RW:0]   trial;
    logic [RW:0]   modulus;
    logic [RW-1:0] period_x;

    always_comb
    begin
        trial = {r_reg, bit_in.dat};
        modulus = {1'b0, period, 1'b0};
        if (trial >= modulus)
        begin
            r_next = RW'(trial - modulus);
        end
        else
        begin
            r_next = trial[RW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            r_reg <= '0;
        end
        else if (bit_in.en)
        begin
            r_reg <= r_next;
        end
    end

    // phase is below 2P, so either difference fits in PW bits
    always_comb
    begin
        period_x = {1'b0, period};
        priority if (period == '0)
        begin
            compare = '0;
        end
        else if (r_reg >= period_x)
        begin
            compare = PW'(r_reg - period_x);
        end
        else
        begin
            compare = period - r_reg[PW-1:0];
        end
    end

endmodule

### design/debounced_stopwatch_digit_display_unit.sv
// Debounced stopwatch: run/stop, clear, decimal display digits and breath compare.
// A new item is taken only when idle; in_stall holds until its result is loaded for output.
// The elapsed time streams MSB first, one bit per cycle, through a chain of eight
// constant dividers (each stage registered) and a parallel mod-2P unit.
// Reset: async active low; running, released, history all ones, times zero, period 1249.
// Depends on dsw_pkg, dsw_div_stage and dsw_breath.
module debounced_stopwatch_digit_display_unit #(
    parameter int unsigned DEBOUNCE_SAMPLES = dsw_pkg::DEBOUNCE_SAMPLES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dsw_pkg::PERIOD_W-1:0]      cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dsw_pkg::TIME_W-1:0]        now_ms,
    input  logic                              clear_pin,
    input  logic                              stop_pin,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        ms_units,
    output logic [3:0]                        ms_tens,
    output logic [3:0]                        ms_hundreds,
    output logic [3:0]                        sec_units,
    output logic [2:0]                        sec_tens,
    output logic [3:0]                        min_units,
    output logic [2:0]                        min_tens,
    output logic [3:0]                        hour_units,
    output logic [dsw_pkg::PERIOD_W-1:0]      breath_compare
);

    localparam int unsigned TW = dsw_pkg::TIME_W;
    localparam int unsigned NS = dsw_pkg::NUM_STAGES;
    localparam int unsigned CW = dsw_pkg::CNT_W;

    dsw_pkg::state_t state_reg;
    dsw_pkg::state_t state_next;

    logic [dsw_pkg::PERIOD_W-1:0]  period_reg;
    logic [TW-1:0]                 start_reg;
    logic [TW-1:0]                 start_next;
    logic [DEBOUNCE_SAMPLES-1:0]   hist_reg;
    logic [DEBOUNCE_SAMPLES-1:0]   hist_next;
    logic                          released_reg;
    logic                          released_next;
    logic                          running_reg;
    logic                          running_next;
    logic [TW-1:0]                 elapsed_reg;
    logic [TW-1:0]                 elapsed_next;
    logic [TW-1:0]                 shift_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          out_valid_reg;

    logic [3:0]                    ms_units_reg;
    logic [3:0]                    ms_tens_reg;
    logic [3:0]                    ms_hundreds_reg;
    logic [3:0]                    sec_units_reg;
    logic [2:0]                    sec_tens_reg;
    logic [3:0]                    min_units_reg;
    logic [2:0]                    min_tens_reg;
    logic [3:0]                    hour_units_reg;
    logic [dsw_pkg::PERIOD_W-1:0]  compare_reg;

    logic accept;
    logic run_en;
    logic out_load;
    logic chain_done;

    dsw_pkg::serial_bit_t link [NS+1];
    logic [dsw_pkg::DIGIT_W-1:0] digit_w [NS];
    logic [dsw_pkg::PERIOD_W-1:0] compare_w;

    // Tick state update, all settled at the transfer edge
    always_comb
    begin
        start_next = clear_pin ? start_reg : now_ms;
        hist_next = {hist_reg[DEBOUNCE_SAMPLES-2:0], stop_pin};
        released_next = released_reg;
        running_next = running_reg;
        priority if (hist_next == '0)
        begin
            if (released_reg)
            begin
                running_next = !running_reg;
            end
            released_next = 1'b0;
        end
        else if (hist_next == '1)
        begin
            released_next = 1'b1;
        end
        else
        begin
            released_next = released_reg;
        end
        elapsed_next = running_next ? (now_ms - start_next) : elapsed_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dsw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dsw_pkg::ST_RUN;
                end
            end
            dsw_pkg::ST_RUN:
            begin
                if (chain_done)
                begin
                    state_next = dsw_pkg::ST_DONE;
                end
            end
            dsw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = dsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != dsw_pkg::ST_IDLE);
        accept = in_valid && (state_reg == dsw_pkg::ST_IDLE);
        run_en = (state_reg == dsw_pkg::ST_RUN) && (cnt_reg < CW'(TW));
        chain_done = (cnt_reg >= CW'(TW)) && !link[NS].en;
        out_load = (state_reg == dsw_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsw_pkg::ST_IDLE;
            period_reg <= dsw_pkg::BREATH_PERIOD_RESET;
            start_reg <= '0;
            hist_reg <= '1;
            released_reg <= 1'b1;
            running_reg <= 1'b1;
            elapsed_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                start_reg <= start_next;
                hist_reg <= hist_next;
                released_reg <= released_next;
                running_reg <= running_next;
                elapsed_reg <= elapsed_next;
                cnt_reg <= '0;
            end
            else if (state_reg == dsw_pkg::ST_RUN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Elapsed time leaves MSB first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg <= elapsed_next;
        end
        else if (run_en)
        begin
            shift_reg <= {shift_reg[TW-2:0], 1'b0};
        end
    end

    assign link[0].en = run_en;
    assign link[0].dat = shift_reg[TW-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        localparam int unsigned DIV = dsw_pkg::DIGIT_DIV[k];
        logic [$clog2(DIV)-1:0] dg;

        dsw_div_stage #(
            .DIVISOR (DIV)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (accept),
            .link_in  (link[k]),
            .link_out (link[k+1]),
            .digit    (dg)
        );

        assign digit_w[k] = dsw_pkg::DIGIT_W'(dg);
    end

    dsw_breath u_breath (
        .clk     (clk),
        .clear   (accept),
        .bit_in  (link[0]),
        .period  (period_reg),
        .compare (compare_w)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            ms_units_reg <= digit_w[dsw_pkg::DIG_MS_UNITS];
            ms_tens_reg <= digit_w[dsw_pkg::DIG_MS_TENS];
            ms_hundreds_reg <= digit_w[dsw_pkg::DIG_MS_HUNDREDS];
            sec_units_reg <= digit_w[dsw_pkg::DIG_SEC_UNITS];
            sec_tens_reg <= digit_w[dsw_pkg::DIG_SEC_TENS][2:0];
            min_units_reg <= digit_w[dsw_pkg::DIG_MIN_UNITS];
            min_tens_reg <= digit_w[dsw_pkg::DIG_MIN_TENS][2:0];
            hour_units_reg <= digit_w[dsw_pkg::DIG_HOUR_UNITS];
            compare_reg <= compare_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign ms_units = ms_units_reg;
    assign ms_tens = ms_tens_reg;
    assign ms_hundreds = ms_hundreds_reg;
    assign sec_units = sec_units_reg;
    assign sec_tens = sec_tens_reg;
    assign min_units = min_units_reg;
    assign min_tens = min_tens_reg;
    assign hour_units = hour_units_reg;
    assign breath_compare = compare_reg;

endmodule

### verif/dsw_checker.sv
// Checker for the debounced stopwatch digit display: predicts each readout from the
// input transfers and config writes, and compares it with the output transfers.
// Depends on dsw_pkg.
`timescale 1ns / 1ps

module dsw_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dsw_pkg::PERIOD_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [dsw_pkg::TIME_W-1:0]    now_ms,
    input  logic                          clear_pin,
    input  logic                          stop_pin,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [3:0]                    ms_units,
    input  logic [3:0]                    ms_tens,
    input  logic [3:0]                    ms_hundreds,
    input  logic [3:0]                    sec_units,
    input  logic [2:0]                    sec_tens,
    input  logic [3:0]                    min_units,
    input  logic [2:0]                    min_tens,
    input  logic [3:0]                    hour_units,
    input  logic [dsw_pkg::PERIOD_W-1:0]  breath_compare,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);

    localparam int unsigned HIST_W = dsw_pkg::DEBOUNCE_SAMPLES_DEF;
    localparam logic [HIST_W-1:0] HIST_ALL_ONES = '1;

    typedef struct packed {
        logic [3:0]                   ms_u;
        logic [3:0]                   ms_t;
        logic [3:0]                   ms_h;
        logic [3:0]                   sec_u;
        logic [2:0]                   sec_t;
        logic [3:0]                   min_u;
        logic [2:0]                   min_t;
        logic [3:0]                   hour_u;
        logic [dsw_pkg::PERIOD_W-1:0] cmp;
    } readout_t;

    logic [dsw_pkg::PERIOD_W-1:0] period_q;
    logic [dsw_pkg::TIME_W-1:0]   start_q;
    logic [dsw_pkg::TIME_W-1:0]   elapsed_q;
    logic [HIST_W-1:0]            hist_q;
    logic                         released_q;
    logic                         running_q;
    readout_t                     readout_q [$];
    int unsigned                  errors;

    // One millisecond tick of the stopwatch; the toggle lands before elapsed is updated.
    task automatic tick_stopwatch(input logic [dsw_pkg::TIME_W-1:0] now, input logic clr,
                                  input logic stp, output readout_t r);
        logic [31:0] e;
        logic [31:0] p;
        logic [31:0] ph;
        if (!clr)
            start_q = now;
        hist_q = {hist_q[HIST_W-2:0], stp};
        if (hist_q == '0)
        begin
            if (released_q)
                running_q = !running_q;
            released_q = 1'b0;
        end
        else if (hist_q == HIST_ALL_ONES)
        begin
            released_q = 1'b1;
        end
        if (running_q)
            elapsed_q = now - start_q;
        e = elapsed_q;
        p = 32'(period_q);
        r.ms_u   = 4'(e % 10);
        r.ms_t   = 4'((e / 10) % 10);
        r.ms_h   = 4'((e / 100) % 10);
        r.sec_u  = 4'((e / 1000) % 10);
        r.sec_t  = 3'((e / 10000) % 6);
        r.min_u  = 4'((e / 60000) % 10);
        r.min_t  = 3'((e / 600000) % 6);
        r.hour_u = 4'((e / 3600000) % 10);
        if (p == 0)
        begin
            r.cmp = '0;
        end
        else
        begin
            ph = e % (p << 1);
            r.cmp = dsw_pkg::PERIOD_W'((ph >= p) ? (ph - p) : (p - ph));
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        readout_t next_r;
        if (!rst_n)
        begin
            period_q   = dsw_pkg::BREATH_PERIOD_RESET;
            start_q    = '0;
            elapsed_q  = '0;
            hist_q     = HIST_ALL_ONES;
            released_q = 1'b1;
            running_q  = 1'b1;
            readout_q.delete();
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                period_q = cfg_wr_data;
            // Pop before push: a result at this edge always belongs to an older transfer
            if (out_valid && !out_stall)
            begin
                if (readout_q.size() == 0)
                begin
                    $display("%0t ns: result transfer with no readout outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = readout_q.pop_front();
                    check_field("ms_units", want.ms_u, ms_units);
                    check_field("ms_tens", want.ms_t, ms_tens);
                    check_field("ms_hundreds", want.ms_h, ms_hundreds);
                    check_field("sec_units", want.sec_u, sec_units);
                    check_field("sec_tens", want.sec_t, sec_tens);
                    check_field("min_units", want.min_u, min_units);
                    check_field("min_tens", want.min_t, min_tens);
                    check_field("hour_units", want.hour_u, hour_units);
                    check_field("breath_compare", want.cmp, breath_compare);
                end
            end
            if (in_valid && !in_stall)
            begin
                tick_stopwatch(now_ms, clear_pin, stop_pin, next_r);
                readout_q.push_back(next_r);
            end
            fail_count <= errors;
            pending    <= readout_q.size();
        end
    end

endmodule

### verif/tb_debounced_stopwatch_digit_display_unit.sv
// Top of the stopwatch testbench: clock, reset, tick stimulus, result back-pressure
// and the verdict. Depends on dsw_pkg, dsw_checker and the block itself.
`timescale 1ns / 1ps

module tb_debounced_stopwatch_digit_display_unit;

    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE = 108;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned SETTLE_CYCLES   = 50;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [dsw_pkg::PERIOD_W-1:0] cfg_wr_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [dsw_pkg::TIME_W-1:0]   now_ms;
    logic                         clear_pin;
    logic                         stop_pin;
    logic                         out_valid;
    logic                         out_stall;
    logic [3:0]                   ms_units;
    logic [3:0]                   ms_tens;
    logic [3:0]                   ms_hundreds;
    logic [3:0]                   sec_units;
    logic [2:0]                   sec_tens;
    logic [3:0]                   min_units;
    logic [2:0]                   min_tens;
    logic [3:0]                   hour_units;
    logic [dsw_pkg::PERIOD_W-1:0] breath_compare;

    int unsigned                  fail_count;
    int unsigned                  pending;
    bit                           tx_busy;
    bit                           rx_hold_req;
    logic [dsw_pkg::TIME_W-1:0]   clock_ms;

    debounced_stopwatch_digit_display_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_ms         (now_ms),
        .clear_pin      (clear_pin),
        .stop_pin       (stop_pin),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ms_units       (ms_units),
        .ms_tens        (ms_tens),
        .ms_hundreds    (ms_hundreds),
        .sec_units      (sec_units),
        .sec_tens       (sec_tens),
        .min_units      (min_units),
        .min_tens       (min_tens),
        .hour_units     (hour_units),
        .breath_compare (breath_compare)
    );

    dsw_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .now_ms         (now_ms),
        .clear_pin      (clear_pin),
        .stop_pin       (stop_pin),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ms_units       (ms_units),
        .ms_tens        (ms_tens),
        .ms_hundreds    (ms_hundreds),
        .sec_units      (sec_units),
        .sec_tens       (sec_tens),
        .min_units      (min_units),
        .min_tens       (min_tens),
        .hour_units     (hour_units),
        .breath_compare (breath_compare),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_debounced_stopwatch_digit_display_unit failed");
        $finish;
    end

    function automatic int unsigned draw_gap(input bit busy);
        return busy ? $urandom_range(0, 17) : 0;
    endfunction

    // valid stays high across back-to-back transfers; this task lowers it only for a gap
    task automatic send_tick(input logic [dsw_pkg::TIME_W-1:0] t, input logic clr,
                             input logic stp);
        int unsigned gap;
        gap = draw_gap(tx_busy);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        now_ms    <= t;
        clear_pin <= clr;
        stop_pin  <= stp;
        do @(posedge clk); while (in_stall);
    endtask

    // Advance the free-running time and send; clear is pressed about once in clr_odds
    task automatic next_tick(input logic stp, input int unsigned clr_odds);
        clock_ms = clock_ms + $urandom_range(0, 3);
        send_tick(clock_ms, ($urandom_range(1, clr_odds) == 1) ? 1'b0 : 1'b1, stp);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        // one edge so the count includes the last transfer
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // idle gap before the next phase starts
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_period(input logic [dsw_pkg::PERIOD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_random(input int unsigned total, input bit long_hold);
        int unsigned done_n;
        int unsigned kind;
        int unsigned len;
        int unsigned i;
        done_n = 0;
        while (done_n < total)
        begin
            tx_busy = ($urandom_range(0, 3) != 0);
            if (long_hold && done_n == 0)
            begin
                // receiver holds off while the sender pushes back-to-back
                rx_hold_req = 1'b1;
                tx_busy = 1'b0;
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // clean press and release: long enough lows and highs to debounce
                len = $urandom_range(16, 22);
                for (i = 0; i < len; i++)
                    next_tick(1'b0, 20);
                done_n += len;
                len = $urandom_range(16, 22);
                for (i = 0; i < len; i++)
                    next_tick(1'b1, 20);
                done_n += len;
            end
            else if (kind <= 7)
            begin
                len = $urandom_range(8, 20);
                for (i = 0; i < len; i++)
                    next_tick(1'($urandom_range(0, 1)), 4);
                done_n += len;
            end
            else if (kind == 8)
            begin
                // time jump, sometimes close to the 32-bit wrap
                if ($urandom_range(0, 1) == 1)
                    clock_ms = $urandom;
                else
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
                len = $urandom_range(2, 6);
                for (i = 0; i < len; i++)
                    next_tick(1'($urandom_range(0, 1)), 3);
                done_n += len;
            end
            else
            begin
                // bounce: press too short to debounce
                len = $urandom_range(4, 15);
                for (i = 0; i < len; i++)
                    next_tick(1'b0, 20);
                done_n += len;
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    next_tick(1'b1, 20);
                done_n += len;
            end
        end
    endtask

    // Result side: random stall per result, plus one long hold-off on request
    initial
    begin
        int unsigned wait_n;
        int unsigned left;
        bit rx_busy;
        out_stall <= 1'b1;
        rx_busy = 1'b1;
        left = 0;
        @(posedge clk);
        forever
        begin
            if (left == 0)
            begin
                rx_busy = ($urandom_range(0, 3) != 0);
                left = $urandom_range(8, 40);
            end
            left--;
            wait_n = draw_gap(rx_busy);
            if (rx_hold_req)
            begin
                wait_n = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        logic [dsw_pkg::PERIOD_W-1:0] periods [NUM_PHASES];
        int unsigned ph;
        int unsigned i;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        now_ms      <= '0;
        clear_pin   <= 1'b1;
        stop_pin    <= 1'b1;
        tx_busy     = 1'b1;
        rx_hold_req = 1'b0;
        periods = '{16'd1, 16'hFFFF, 16'd0,
                    dsw_pkg::PERIOD_W'($urandom_range(2, 65534)),
                    dsw_pkg::PERIOD_W'($urandom_range(2, 65534)),
                    dsw_pkg::BREATH_PERIOD_RESET};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: field extremes at the reset period
        send_tick(32'h0000_0000, 1'b0, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_tick(32'h8000_0000, 1'b1, 1'b1);
        send_tick(32'h0000_0001, 1'b0, 1'b1);
        send_tick(32'h5A5A_A5A5, 1'b1, 1'b1);
        // held stop: toggles to stopped on the sixteenth low sample
        clock_ms = 32'd4000;
        for (i = 0; i < 16; i++)
        begin
            clock_ms = clock_ms + 7;
            send_tick(clock_ms, 1'b1, 1'b0);
        end
        // still held and cleared while stopped: no second toggle, display frozen
        send_tick(clock_ms + 11, 1'b0, 1'b0);
        send_tick(clock_ms + 23, 1'b1, 1'b0);
        clock_ms = clock_ms + 40;
        send_tick(clock_ms, 1'b1, 1'b1);
        wait_drained();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_period(periods[ph]);
            run_random(ITEMS_PER_PHASE, ph == 1);
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_debounced_stopwatch_digit_display_unit passed");
        else
            $display("tb_debounced_stopwatch_digit_display_unit failed");
        $finish;
    end

endmodule

### sim.f
design/dsw_pkg.sv
design/dsw_div_stage.sv
design/dsw_breath.sv
design/debounced_stopwatch_digit_display_unit.sv
verif/dsw_checker.sv
verif/tb_debounced_stopwatch_digit_display_unit.sv
